/* sv/dpd_pkg.sv */
// ----------------------------------------------------------------------------
// dpd_pkg
// Shared types, format constants and small helpers of the packet deframer.
// ----------------------------------------------------------------------------
package dpd_pkg;

    // width of in-packet offsets and byte counts (longest packet is 2064 bytes)
    localparam int REL_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int SLICE_BYTES = 64;
    localparam int SLICE_W    = SLICE_BYTES * 8;

    // packet format codes
    localparam logic [1:0] MODE_SPEC512 = 2'd0;
    localparam logic [1:0] MODE_SPEC16  = 2'd1;
    localparam logic [1:0] MODE_WAVE    = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAG     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAPTURE = 2'd2;

    // header / tail patterns
    localparam logic [7:0]  HEAD_B0   = 8'haa;
    localparam logic [7:0]  HEAD_B1   = 8'hbb;
    localparam logic [31:0] TAIL_LONG = 32'hccdd0000;
    localparam logic [15:0] TAIL_SHORT = 16'hccdd;

    // spectrum formats
    localparam logic [REL_W-1:0] SPEC_HLEN     = 12'd4;
    localparam logic [REL_W-1:0] SPEC512_PLEN  = 12'd2064;
    localparam logic [REL_W-1:0] SPEC16_PLEN   = 12'd80;
    localparam logic [REL_W-1:0] SPEC_FLD_OFF  = 12'd4;
    localparam logic [REL_W-1:0] SPEC_FLD_END  = 12'd12;
    localparam logic [REL_W-1:0] SPEC_PAY_OFF  = 12'd12;
    // waveform format
    localparam logic [REL_W-1:0] WAVE_HLEN     = 12'd2;
    localparam logic [REL_W-1:0] WAVE_PLEN     = 12'd2056;
    localparam logic [REL_W-1:0] WAVE_FLD_OFF  = 12'd2;
    localparam logic [REL_W-1:0] WAVE_FLD_END  = 12'd6;
    localparam logic [REL_W-1:0] WAVE_PAY_OFF  = 12'd6;

    // slice builder control and status
    typedef struct packed {
        logic push;
        logic last;
        logic clear;
    } slc_ctl_t;

    typedef struct packed {
        logic can_issue;
        logic last_sent;
    } slc_stat_t;

    // header byte expected at match position k
    function automatic logic [7:0] head_byte(input logic [1:0] k);
        logic [7:0] b;
        unique case (k)
            2'd0:    b = HEAD_B0;
            2'd1:    b = HEAD_B1;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // sliding header match step; header has no self overlap
    function automatic logic [1:0] head_step(input logic [1:0] k, input logic [7:0] b);
        logic [1:0] n;
        if (b == head_byte(k))
            n = k + 2'd1;
        else if (b == HEAD_B0)
            n = 2'd1;
        else
            n = 2'd0;
        return n;
    endfunction

    // channel 1-16 from lowest set mask bit, 0 if none
    function automatic logic [4:0] lowest_channel(input logic [15:0] mask);
        logic [4:0] ch;
        ch = 5'd0;
        for (int b = 15; b >= 0; b--) begin
            if (mask[b])
                ch = 5'(b + 1);
        end
        return ch;
    endfunction

endpackage

/* sv/dpd_ifs.sv */
// ----------------------------------------------------------------------------
// dpd interfaces
// Byte input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface dpd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dpd_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] payload_0;
    logic [63:0] payload_1;
    logic [63:0] payload_2;
    logic [63:0] payload_3;
    logic [63:0] payload_4;
    logic [63:0] payload_5;
    logic [63:0] payload_6;
    logic [63:0] payload_7;
    logic [4:0]  channel_number;
    logic [31:0] timestamp;
    logic [1:0]  detector_id;
    logic        last_of_run;

    modport source (output valid, output payload_0, output payload_1, output payload_2,
                    output payload_3, output payload_4, output payload_5, output payload_6,
                    output payload_7, output channel_number, output timestamp,
                    output detector_id, output last_of_run, input ready);
    modport sink   (input valid, input payload_0, input payload_1, input payload_2,
                    input payload_3, input payload_4, input payload_5, input payload_6,
                    input payload_7, input channel_number, input timestamp,
                    input detector_id, input last_of_run, output ready);
endinterface

interface dpd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [dpd_pkg::CFG_IDX_W-1:0]  index;
    logic [dpd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/dpd_store.sv */
// ----------------------------------------------------------------------------
// dpd_store
// Byte buffer RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dpd_store #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // read port, registered data
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/dpd_slicer.sv */
// ----------------------------------------------------------------------------
// dpd_slicer
// Packs payload bytes into 64-byte slices and holds the result word register.
// ----------------------------------------------------------------------------
module dpd_slicer (
    input  logic              clk,
    input  logic              rst_n,
    input  dpd_pkg::slc_ctl_t ctl,
    input  logic [7:0]        pay_byte,
    input  logic [4:0]        channel,
    input  logic [31:0]       stamp,
    input  logic [1:0]        tag,
    output dpd_pkg::slc_stat_t stat,
    dpd_result_if.source      res
);

    logic [dpd_pkg::SLICE_W-1:0] acc_reg, acc_next;
    logic [5:0]  bcnt_reg, bcnt_next;
    logic        full_reg, full_next;
    logic        full_last_reg, full_last_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] pay_reg [8];
    logic [4:0]  ch_reg;
    logic [31:0] ts_reg;
    logic [1:0]  id_reg;
    logic        last_reg;
    logic        move;

    // slice moves to the word register when that is free or being taken
    assign move = full_reg && (!out_valid_reg || res.ready);

    always_comb
    begin
        acc_next       = acc_reg;
        bcnt_next      = bcnt_reg;
        full_next      = full_reg;
        full_last_next = full_last_reg;
        out_valid_next = out_valid_reg;

        // output word handshake
        if (move)
        begin
            out_valid_next = 1'b1;
            full_next      = 1'b0;
        end
        else if (res.ready)
            out_valid_next = 1'b0;

        // byte arrival
        if (ctl.push)
        begin
            acc_next  = {acc_reg[dpd_pkg::SLICE_W-9:0], pay_byte};
            bcnt_next = bcnt_reg + 6'd1;
            if (bcnt_reg == 6'd63)
            begin
                full_next      = 1'b1;
                full_last_next = ctl.last;
            end
        end

        if (ctl.clear)
        begin
            bcnt_next = 6'd0;
            full_next = 1'b0;
        end
    end

    assign stat.can_issue = !full_reg && !(ctl.push && bcnt_reg == 6'd63);
    assign stat.last_sent = move && full_last_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcnt_reg      <= 6'd0;
            full_reg      <= 1'b0;
            full_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bcnt_reg      <= bcnt_next;
            full_reg      <= full_next;
            full_last_reg <= full_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (move)
        begin
            for (int w = 0; w < 8; w++)
                pay_reg[w] <= acc_reg[dpd_pkg::SLICE_W-1-64*w -: 64];
            ch_reg   <= channel;
            ts_reg   <= stamp;
            id_reg   <= tag;
            last_reg <= full_last_reg;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.payload_0      = pay_reg[0];
    assign res.payload_1      = pay_reg[1];
    assign res.payload_2      = pay_reg[2];
    assign res.payload_3      = pay_reg[3];
    assign res.payload_4      = pay_reg[4];
    assign res.payload_5      = pay_reg[5];
    assign res.payload_6      = pay_reg[6];
    assign res.payload_7      = pay_reg[7];
    assign res.channel_number = ch_reg;
    assign res.timestamp      = ts_reg;
    assign res.detector_id    = id_reg;
    assign res.last_of_run    = last_reg;

endmodule

/* sv/detector_packet_deframer_core.sv */
// ----------------------------------------------------------------------------
// detector_packet_deframer_core
// Header search, packet buffering, tail check and payload slicing of
// detector packets in three formats.
//
//   channel | dir | handshake        | word
//   rx      | in  | valid / ready    | rx_byte
//   res     | out | valid / ready    | 64-byte payload slice plus packet fields
//   cfg     | in  | valid / ready    | register index and data
//
// While searching or collecting one byte is taken every cycle.
// A full packet is then read back through the single buffer read port:
// tail, then fields, then payload slice by slice, where output stalls can
// hold the payload reads. A bad tail rescans the buffered packet one byte
// a cycle. Reset needs no clearing pass.
// ----------------------------------------------------------------------------
module detector_packet_deframer_core #(
    parameter int STORE_BYTES = 4096
) (
    input  logic          clk,
    input  logic          rst_n,
    dpd_byte_if.sink      rx,
    dpd_result_if.source  res,
    dpd_cfg_if.sink       cfg
);

    localparam int AW = $clog2(STORE_BYTES);
    localparam logic [AW:0] DEPTH = (AW+1)'(STORE_BYTES);
    localparam int RW = dpd_pkg::REL_W;

    localparam logic [2:0] S_SCAN    = 3'd0;
    localparam logic [2:0] S_COLLECT = 3'd1;
    localparam logic [2:0] S_TAIL    = 3'd2;
    localparam logic [2:0] S_FIELD   = 3'd3;
    localparam logic [2:0] S_PAY     = 3'd4;
    localparam logic [2:0] S_RESCAN  = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [1:0]    mode_reg, mode_next;
    logic [1:0]    tag_reg, tag_next;
    logic          cap_reg, cap_next;
    logic [1:0]    k_reg, k_next;
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] base_reg, base_next;
    logic [RW-1:0] count_reg, count_next;
    logic [RW-1:0] rd_rel_reg, rd_rel_next;
    logic [RW-1:0] rd_end_reg, rd_end_next;
    logic          pend_reg, pend_next;
    logic          pend_last_reg, pend_last_next;
    logic [RW-1:0] pend_rel_reg, pend_rel_next;
    logic [AW-1:0] pend_addr_reg, pend_addr_next;
    logic [63:0]   fld_reg, fld_next;
    logic [4:0]    ch_reg, ch_next;
    logic [31:0]   ts_reg, ts_next;

    // format decode
    logic          is_wave, is_s16;
    logic [RW-1:0] hlen, hm1, plen, fld_off, fld_end, pay_off, pay_end;

    // buffer ports
    logic          wr_en, rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic [AW:0]   rd_sum;
    logic [AW-1:0] wr_ptr_inc, scan_base, rescan_base;

    logic          rx_fire, cfg_fire, issue;
    logic          scan_hit, rescan_hit, tail_ok, drop_pkt;
    logic [63:0]   fld_sh;
    logic [31:0]   raw_ch;
    logic [4:0]    ch_calc;
    logic [31:0]   ts_calc;

    dpd_pkg::slc_ctl_t  slc_ctl;
    dpd_pkg::slc_stat_t slc_stat;

    // format decode, mode three acts as spectrum 512
    assign is_wave = (mode_reg == dpd_pkg::MODE_WAVE);
    assign is_s16  = (mode_reg == dpd_pkg::MODE_SPEC16);
    assign hlen    = is_wave ? dpd_pkg::WAVE_HLEN : dpd_pkg::SPEC_HLEN;
    assign hm1     = hlen - RW'(1);
    assign plen    = is_wave ? dpd_pkg::WAVE_PLEN :
                     (is_s16 ? dpd_pkg::SPEC16_PLEN : dpd_pkg::SPEC512_PLEN);
    assign fld_off = is_wave ? dpd_pkg::WAVE_FLD_OFF : dpd_pkg::SPEC_FLD_OFF;
    assign fld_end = is_wave ? dpd_pkg::WAVE_FLD_END : dpd_pkg::SPEC_FLD_END;
    assign pay_off = is_wave ? dpd_pkg::WAVE_PAY_OFF : dpd_pkg::SPEC_PAY_OFF;
    assign pay_end = plen - hlen;

    // handshakes
    assign rx.ready  = (state_reg == S_SCAN) || (state_reg == S_COLLECT);
    assign cfg.ready = 1'b1;
    assign rx_fire   = rx.valid && rx.ready;
    assign cfg_fire  = cfg.valid && cfg.ready;
    assign wr_en     = rx_fire && cap_reg;

    // circular buffer addressing
    assign wr_ptr_inc = (wr_ptr_reg == AW'(STORE_BYTES - 1)) ? '0 : wr_ptr_reg + AW'(1);
    assign rd_sum     = {1'b0, base_reg} + {{(AW+1-RW){1'b0}}, rd_rel_reg};
    assign rd_addr    = (rd_sum >= DEPTH) ? AW'(rd_sum - DEPTH) : AW'(rd_sum);

    always_comb
    begin
        logic [AW:0] d_ext;
        d_ext = {{(AW+1-RW){1'b0}}, hm1};
        if ({1'b0, wr_ptr_reg} >= d_ext)
            scan_base = AW'({1'b0, wr_ptr_reg} - d_ext);
        else
            scan_base = AW'({1'b0, wr_ptr_reg} + DEPTH - d_ext);
        if ({1'b0, pend_addr_reg} >= d_ext)
            rescan_base = AW'({1'b0, pend_addr_reg} - d_ext);
        else
            rescan_base = AW'({1'b0, pend_addr_reg} + DEPTH - d_ext);
    end

    // read issue
    always_comb
    begin
        issue = 1'b0;
        if (rd_rel_reg < rd_end_reg)
        begin
            priority case (state_reg)
                S_TAIL, S_FIELD, S_RESCAN: issue = 1'b1;
                S_PAY:                     issue = slc_stat.can_issue;
                default:                   issue = 1'b0;
            endcase
        end
    end
    assign rd_en = issue;

    // header match on incoming and on rescanned bytes
    assign scan_hit   = (rx.rx_byte == dpd_pkg::head_byte(k_reg)) && (k_reg == hm1[1:0]);
    assign rescan_hit = (rd_data == dpd_pkg::head_byte(k_reg)) && (k_reg == hm1[1:0]);

    // tail and field decode on the shifted read bytes
    assign fld_sh  = {fld_reg[55:0], rd_data};
    assign tail_ok = is_wave ? (fld_sh[15:0] == dpd_pkg::TAIL_SHORT)
                             : (fld_sh[31:0] == dpd_pkg::TAIL_LONG);
    assign raw_ch  = fld_sh[31:0];

    always_comb
    begin
        if (is_wave)
        begin
            ch_calc = dpd_pkg::lowest_channel(fld_sh[31:16]);
            ts_calc = {16'd0, fld_sh[15:0]};
        end
        else
        begin
            ts_calc = fld_sh[63:32];
            if (is_s16 && raw_ch >= 32'd1 && raw_ch <= 32'd16)
                ch_calc = raw_ch[4:0];
            else
                ch_calc = dpd_pkg::lowest_channel(raw_ch[15:0]);
        end
    end
    assign drop_pkt = is_s16 && (ch_calc == 5'd0);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        tag_next       = tag_reg;
        cap_next       = cap_reg;
        k_next         = k_reg;
        wr_ptr_next    = wr_ptr_reg;
        base_next      = base_reg;
        count_next     = count_reg;
        rd_rel_next    = issue ? rd_rel_reg + RW'(1) : rd_rel_reg;
        rd_end_next    = rd_end_reg;
        pend_next      = issue;
        pend_last_next = issue && (rd_rel_reg + RW'(1) == rd_end_reg);
        pend_rel_next  = rd_rel_reg;
        pend_addr_next = rd_addr;
        fld_next       = fld_reg;
        ch_next        = ch_reg;
        ts_next        = ts_reg;
        slc_ctl.push   = pend_reg && (state_reg == S_PAY);
        slc_ctl.last   = pend_last_reg;
        slc_ctl.clear  = 1'b0;

        if (pend_reg && (state_reg == S_TAIL || state_reg == S_FIELD))
            fld_next = fld_sh;

        unique case (state_reg)
            S_SCAN:
            begin
                if (wr_en)
                begin
                    wr_ptr_next = wr_ptr_inc;
                    if (scan_hit)
                    begin
                        base_next  = scan_base;
                        count_next = hlen;
                        k_next     = 2'd0;
                        state_next = S_COLLECT;
                    end
                    else
                        k_next = dpd_pkg::head_step(k_reg, rx.rx_byte);
                end
            end
            S_COLLECT:
            begin
                if (wr_en)
                begin
                    wr_ptr_next = wr_ptr_inc;
                    count_next  = count_reg + RW'(1);
                    if (count_reg + RW'(1) == plen)
                    begin
                        rd_rel_next = plen - hlen;
                        rd_end_next = plen;
                        state_next  = S_TAIL;
                    end
                end
            end
            S_TAIL:
            begin
                if (pend_reg && pend_last_reg)
                begin
                    if (tail_ok)
                    begin
                        rd_rel_next = fld_off;
                        rd_end_next = fld_end;
                        state_next  = S_FIELD;
                    end
                    else
                    begin
                        rd_rel_next = hlen;
                        rd_end_next = plen;
                        k_next      = 2'd0;
                        state_next  = S_RESCAN;
                    end
                end
            end
            S_FIELD:
            begin
                if (pend_reg && pend_last_reg)
                begin
                    ch_next = ch_calc;
                    ts_next = ts_calc;
                    if (drop_pkt)
                    begin
                        k_next     = 2'd0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        rd_rel_next = pay_off;
                        rd_end_next = pay_end;
                        state_next  = S_PAY;
                    end
                end
            end
            S_PAY:
            begin
                if (slc_stat.last_sent)
                begin
                    k_next     = 2'd0;
                    state_next = S_SCAN;
                end
            end
            S_RESCAN:
            begin
                if (pend_reg)
                begin
                    if (rescan_hit)
                    begin
                        base_next  = rescan_base;
                        count_next = plen - pend_rel_reg + hm1;
                        k_next     = 2'd0;
                        pend_next  = 1'b0;
                        state_next = S_COLLECT;
                    end
                    else
                    begin
                        k_next = dpd_pkg::head_step(k_reg, rd_data);
                        if (pend_last_reg)
                            state_next = S_SCAN;
                    end
                end
            end
            default:
            begin
                k_next     = 2'd0;
                state_next = S_SCAN;
            end
        endcase

        // register write clears the buffer
        if (cfg_fire && cfg.index <= dpd_pkg::REG_CAPTURE)
        begin
            unique case (cfg.index)
                dpd_pkg::REG_MODE:    mode_next = cfg.data[1:0];
                dpd_pkg::REG_TAG:     tag_next  = cfg.data[1:0];
                dpd_pkg::REG_CAPTURE: cap_next  = cfg.data[0];
                default:              cap_next  = cap_reg;
            endcase
            k_next        = 2'd0;
            pend_next     = 1'b0;
            rd_end_next   = rd_rel_reg;
            state_next    = S_SCAN;
            slc_ctl.clear = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SCAN;
            mode_reg      <= dpd_pkg::MODE_SPEC512;
            tag_reg       <= 2'd1;
            cap_reg       <= 1'b0;
            k_reg         <= 2'd0;
            wr_ptr_reg    <= '0;
            base_reg      <= '0;
            count_reg     <= '0;
            rd_rel_reg    <= '0;
            rd_end_reg    <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            tag_reg       <= tag_next;
            cap_reg       <= cap_next;
            k_reg         <= k_next;
            wr_ptr_reg    <= wr_ptr_next;
            base_reg      <= base_next;
            count_reg     <= count_next;
            rd_rel_reg    <= rd_rel_next;
            rd_end_reg    <= rd_end_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_rel_reg  <= pend_rel_next;
        pend_addr_reg <= pend_addr_next;
        fld_reg       <= fld_next;
        ch_reg        <= ch_next;
        ts_reg        <= ts_next;
    end

    dpd_store #(
        .DEPTH (STORE_BYTES),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_ptr_reg),
        .wr_data (rx.rx_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dpd_slicer u_slicer (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (slc_ctl),
        .pay_byte (rd_data),
        .channel  (ch_reg),
        .stamp    (ts_reg),
        .tag      (tag_reg),
        .stat     (slc_stat),
        .res      (res)
    );

endmodule

/* test/dpd_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dpd_checker
// Watches the byte, result and configuration channels of the packet
// deframer, keeps its own copy of the byte buffer and the registers, works
// out the payload slices each accepted byte should release and compares
// every accepted result word with the oldest expected slice.
// ----------------------------------------------------------------------------
module dpd_checker (
    input  logic    clk,
    input  logic    rst_n,
    dpd_byte_if     rx,
    dpd_result_if   res,
    dpd_cfg_if      cfg,
    output int      fails,
    output int      pending
);

    typedef struct packed {
        logic [7:0][63:0] pay;
        logic [4:0]       chan;
        logic [31:0]      stamp;
        logic [1:0]       det;
        logic             last;
    } slice_t;

    localparam int BUF_BYTES = 4096;

    logic [7:0] held[$];
    slice_t     slices_due[$];
    logic [1:0] fmt_sel;
    logic [1:0] tag_reg;
    logic       capture_on;

    task automatic report(input string what, input logic [63:0] got,
                          input logic [63:0] want);
        $display("mismatch: %s got %h want %h at %0t", what, got, want, $realtime);
        fails++;
    endtask

    function automatic logic [31:0] read_be(input int pos, input int len);
        logic [31:0] v;
        v = '0;
        for (int i = 0; i < len; i++)
            v = {v[23:0], held[pos + i]};
        return v;
    endfunction

    function automatic logic [4:0] first_channel(input logic [15:0] mask);
        for (int b = 0; b < 16; b++)
            if (mask[b])
                return 5'(b + 1);
        return 5'd0;
    endfunction

    function automatic logic [7:0] head_at(input int k);
        return (k == 0) ? 8'haa : (k == 1) ? 8'hbb : 8'h00;
    endfunction

    function automatic logic [7:0] tail_at(input int k);
        return (k == 0) ? 8'hcc : (k == 1) ? 8'hdd : 8'h00;
    endfunction

    // queue the slices of the packet sitting at the front of the buffer
    task automatic release_packet(input logic [1:0] fmt);
        logic [31:0] raw;
        logic [4:0]  chan;
        logic [31:0] stamp;
        int          off;
        int          nslc;
        slice_t      s;
        if (fmt == dpd_pkg::MODE_WAVE) begin
            chan  = first_channel(read_be(2, 2));
            stamp = read_be(4, 2);
            off   = 6;
            nslc  = 32;
        end else begin
            raw   = read_be(8, 4);
            stamp = read_be(4, 4);
            off   = 12;
            nslc  = (fmt == dpd_pkg::MODE_SPEC16) ? 1 : 32;
            if (fmt == dpd_pkg::MODE_SPEC16 && raw >= 1 && raw <= 16)
                chan = raw[4:0];
            else
                chan = first_channel(raw[15:0]);
            // spectrum 16 without any channel is swallowed
            if (fmt == dpd_pkg::MODE_SPEC16 && chan == 5'd0)
                return;
        end
        for (int k = 0; k < nslc; k++) begin
            for (int w = 0; w < 8; w++)
                for (int i = 0; i < 8; i++)
                    s.pay[w][63 - 8*i -: 8] = held[off + k*64 + w*8 + i];
            s.chan  = chan;
            s.stamp = stamp;
            s.det   = tag_reg;
            s.last  = (k == nslc - 1);
            slices_due.push_back(s);
        end
    endtask

    // one accepted byte: store, search header, check tail, release
    task automatic absorb_byte(input logic [7:0] b);
        logic [1:0] fmt;
        int hlen, plen, found, keep, n;
        bit ok;
        fmt  = (fmt_sel == 2'd3) ? dpd_pkg::MODE_SPEC512 : fmt_sel;
        hlen = (fmt == dpd_pkg::MODE_WAVE) ? 2 : 4;
        plen = (fmt == dpd_pkg::MODE_WAVE) ? 2056 :
               (fmt == dpd_pkg::MODE_SPEC16) ? 80 : 2064;
        if (!capture_on)
            return;
        if (held.size() < BUF_BYTES)
            held.push_back(b);
        while (held.size() >= hlen) begin
            n = held.size();
            found = n;
            for (int i = 0; i + hlen <= n && found == n; i++) begin
                ok = 1;
                for (int j = 0; j < hlen; j++)
                    if (held[i + j] != head_at(j))
                        ok = 0;
                if (ok)
                    found = i;
            end
            if (found == n) begin
                // keep only a trailing partial header
                keep = 0;
                for (int len = hlen - 1; len >= 1 && keep == 0; len--) begin
                    ok = (len <= n);
                    for (int j = 0; j < len && ok; j++)
                        if (held[n - len + j] != head_at(j))
                            ok = 0;
                    if (ok)
                        keep = len;
                end
                held = held[n - keep : $];
                if (keep == 0)
                    held.delete();
                break;
            end
            if (found > 0)
                held = held[found : $];
            if (held.size() < plen)
                break;
            ok = 1;
            for (int j = 0; j < hlen; j++)
                if (held[plen - hlen + j] != tail_at(j))
                    ok = 0;
            if (!ok) begin
                held = held[hlen : $];
                continue;
            end
            release_packet(fmt);
            if (held.size() == plen)
                held.delete();
            else
                held = held[plen : $];
        end
    endtask

    // compare one accepted result word with the oldest slice
    task automatic check_slice();
        slice_t want;
        logic [63:0] got_pay [8];
        got_pay[0] = res.payload_0;
        got_pay[1] = res.payload_1;
        got_pay[2] = res.payload_2;
        got_pay[3] = res.payload_3;
        got_pay[4] = res.payload_4;
        got_pay[5] = res.payload_5;
        got_pay[6] = res.payload_6;
        got_pay[7] = res.payload_7;
        if (slices_due.size() == 0) begin
            report("result word with none expected", got_pay[0], '0);
            return;
        end
        want = slices_due.pop_front();
        for (int w = 0; w < 8; w++)
            if (got_pay[w] !== want.pay[w])
                report($sformatf("payload_%0d", w), got_pay[w], want.pay[w]);
        if (res.channel_number !== want.chan)
            report("channel_number", 64'(res.channel_number), 64'(want.chan));
        if (res.timestamp !== want.stamp)
            report("timestamp", 64'(res.timestamp), 64'(want.stamp));
        if (res.detector_id !== want.det)
            report("detector_id", 64'(res.detector_id), 64'(want.det));
        if (res.last_of_run !== want.last)
            report("last_of_run", 64'(res.last_of_run), 64'(want.last));
    endtask

    // channel monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held.delete();
            slices_due.delete();
            fmt_sel    = dpd_pkg::MODE_SPEC512;
            tag_reg    = 2'd1;
            capture_on = 1'b0;
            fails      = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == dpd_pkg::REG_MODE)
                    fmt_sel = cfg.data[1:0];
                else if (cfg.index == dpd_pkg::REG_TAG)
                    tag_reg = cfg.data[1:0];
                else if (cfg.index == dpd_pkg::REG_CAPTURE)
                    capture_on = cfg.data[0];
                if (cfg.index <= dpd_pkg::REG_CAPTURE)
                    held.delete();
            end
            if (rx.valid && rx.ready)
                absorb_byte(rx.rx_byte);
            if (res.valid && res.ready)
                check_slice();
            pending = slices_due.size();
        end
    end

endmodule

/* test/tb_detector_packet_deframer_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_detector_packet_deframer_core
// Feeds framed detector packets of all formats, corrupted tails, split and
// partial headers and noise into the deframer under random idling on both
// sides; the checker predicts and compares every payload slice.
// ----------------------------------------------------------------------------
module tb_detector_packet_deframer_core;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_WAIT  = 4500;

    logic clk;
    logic rst_n;
    int   fails;
    int   pending;
    int   cycles;
    bit   calm;

    logic [7:0] frame[$];

    dpd_byte_if   rx ();
    dpd_result_if res ();
    dpd_cfg_if    cfg ();

    detector_packet_deframer_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .res   (res),
        .cfg   (cfg)
    );

    dpd_checker chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx),
        .res     (res),
        .cfg     (cfg),
        .fails   (fails),
        .pending (pending)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // result receiver with random stalls
    always @(posedge clk)
    begin
        if (rst_n)
            res.ready <= calm || ($urandom_range(99) >= 24);
    end

    task automatic send_byte(input logic [7:0] b);
        rx.valid   <= 1'b1;
        rx.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx.ready);
        if (!calm && $urandom_range(99) < 24)
        begin
            rx.valid <= 1'b0;
            repeat ($urandom_range(3, 1))
                @(posedge clk);
        end
    endtask

    task automatic send_frame();
        foreach (frame[i])
            send_byte(frame[i]);
        frame.delete();
        rx.valid <= 1'b0;
    endtask

    // fill: 0 random, 1 all zero, 2 all ones
    task automatic build_frame(input logic [1:0] fmt, input logic [31:0] stamp,
                               input logic [31:0] chan_raw, input bit tail_ok,
                               input int fill);
        int npay;
        frame.push_back(8'haa);
        frame.push_back(8'hbb);
        if (fmt == dpd_pkg::MODE_WAVE)
        begin
            frame.push_back(chan_raw[15:8]);
            frame.push_back(chan_raw[7:0]);
            frame.push_back(stamp[15:8]);
            frame.push_back(stamp[7:0]);
        end
        else
        begin
            frame.push_back(8'h00);
            frame.push_back(8'h00);
            for (int i = 3; i >= 0; i--)
                frame.push_back(stamp[8*i +: 8]);
            for (int i = 3; i >= 0; i--)
                frame.push_back(chan_raw[8*i +: 8]);
        end
        npay = (fmt == dpd_pkg::MODE_SPEC16) ? 64 : 2048;
        for (int i = 0; i < npay; i++)
            frame.push_back(fill == 1 ? 8'h00 : fill == 2 ? 8'hff : 8'($urandom_range(255)));
        frame.push_back(tail_ok ? 8'hcc : 8'hc4);
        frame.push_back(8'hdd);
        if (fmt != dpd_pkg::MODE_WAVE)
        begin
            frame.push_back(8'h00);
            frame.push_back(8'h00);
        end
    endtask

    task automatic send_packet(input logic [1:0] fmt, input logic [31:0] chan_raw,
                               input bit tail_ok, input int fill);
        build_frame(fmt, $urandom, chan_raw, tail_ok, fill);
        send_frame();
    endtask

    task automatic write_reg(input logic [dpd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dpd_pkg::CFG_DATA_W-1:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait until all slices are out and the block has gone quiet
    task automatic settle();
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT)
            @(posedge clk);
    endtask

    task automatic set_phase(input logic [1:0] fmt, input logic [1:0] tag, input bit cap);
        settle();
        write_reg(dpd_pkg::REG_MODE, {6'd0, fmt});
        write_reg(dpd_pkg::REG_TAG, {6'd0, tag});
        write_reg(dpd_pkg::REG_CAPTURE, {7'd0, cap});
    endtask

    function automatic logic [31:0] pick_channel();
        case ($urandom_range(5))
            0:       return 32'($urandom_range(16, 1));
            1:       return 32'd0;
            2:       return {16'($urandom_range(65535, 1)), 16'd0};
            3:       return 32'(1) << $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int kind;
        rst_n      = 1'b0;
        calm       = 1'b0;
        cycles     = 0;
        rx.valid   = 1'b0;
        rx.rx_byte = 8'h00;
        res.ready  = 1'b0;
        cfg.valid  = 1'b0;
        cfg.index  = dpd_pkg::REG_MODE;
        cfg.data   = '0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // capture off after reset: bytes are discarded
        send_packet(dpd_pkg::MODE_SPEC512, 32'h1, 1'b1, 0);

        // spectrum 16, directed channel and framing cases
        set_phase(dpd_pkg::MODE_SPEC16, 2'd2, 1'b1);
        send_packet(dpd_pkg::MODE_SPEC16, 32'd5, 1'b1, 1);
        send_packet(dpd_pkg::MODE_SPEC16, 32'd16, 1'b1, 2);
        send_packet(dpd_pkg::MODE_SPEC16, 32'd0, 1'b1, 0);
        send_packet(dpd_pkg::MODE_SPEC16, 32'h0002_0000, 1'b1, 0);
        send_packet(dpd_pkg::MODE_SPEC16, 32'd17, 1'b1, 0);
        send_packet(dpd_pkg::MODE_SPEC16, 32'h0000_8000, 1'b1, 0);
        send_packet(dpd_pkg::MODE_SPEC16, 32'hffff_ffff, 1'b1, 2);
        send_packet(dpd_pkg::MODE_SPEC16, 32'd3, 1'b0, 0);
        send_packet(dpd_pkg::MODE_SPEC16, 32'd4, 1'b1, 0);
        // partial headers ahead of a real one
        send_byte(8'haa);
        send_byte(8'hbb);
        send_byte(8'h00);
        send_packet(dpd_pkg::MODE_SPEC16, 32'd7, 1'b1, 0);
        send_byte(8'haa);
        send_packet(dpd_pkg::MODE_SPEC16, 32'd9, 1'b1, 0);
        // write to the unlisted index leaves buffer and registers alone
        settle();
        send_byte(8'haa);
        send_byte(8'hbb);
        rx.valid <= 1'b0;
        write_reg(2'd3, 8'hff);
        send_byte(8'h00);
        send_byte(8'h00);
        frame.delete();
        build_frame(dpd_pkg::MODE_SPEC16, 32'h1234_5678, 32'd2, 1'b1, 0);
        frame = frame[4:$];
        send_frame();

        // large spectrum: no channel, then a bad tail that forces a rescan
        set_phase(dpd_pkg::MODE_SPEC512, 2'd1, 1'b1);
        send_packet(dpd_pkg::MODE_SPEC512, 32'd0, 1'b1, 0);
        send_packet(dpd_pkg::MODE_SPEC512, 32'h0000_0400, 1'b0, 0);
        send_packet(dpd_pkg::MODE_SPEC512, 32'hffff_0001, 1'b1, 2);

        // waveform
        set_phase(dpd_pkg::MODE_WAVE, 2'd2, 1'b1);
        send_packet(dpd_pkg::MODE_WAVE, 32'h8000, 1'b1, 0);
        send_packet(dpd_pkg::MODE_WAVE, 32'h0000, 1'b1, 1);

        // unused format code behaves as large spectrum
        set_phase(2'd3, 2'd1, 1'b1);
        send_packet(dpd_pkg::MODE_SPEC512, 32'h0000_0010, 1'b1, 0);

        // capture switched off again
        set_phase(dpd_pkg::MODE_SPEC16, 2'd1, 1'b0);
        send_packet(dpd_pkg::MODE_SPEC16, 32'd1, 1'b1, 0);

        // random spectrum 16 traffic
        set_phase(dpd_pkg::MODE_SPEC16, 2'd2, 1'b1);
        for (int p = 0; p < 220; p++)
        begin
            calm = (p >= 40 && p < 75);
            kind = $urandom_range(99);
            if (kind < 78)
                send_packet(dpd_pkg::MODE_SPEC16, pick_channel(), 1'b1, 0);
            else if (kind < 88)
                send_packet(dpd_pkg::MODE_SPEC16, pick_channel(), 1'b0, 0);
            else
            begin
                repeat ($urandom_range(6, 1))
                    send_byte($urandom_range(3) == 0 ? 8'haa : 8'($urandom_range(255)));
                rx.valid <= 1'b0;
            end
        end
        calm = 1'b0;

        // random waveform traffic
        set_phase(dpd_pkg::MODE_WAVE, 2'd1, 1'b1);
        send_packet(dpd_pkg::MODE_WAVE, $urandom, 1'b1, 0);
        send_packet(dpd_pkg::MODE_WAVE, $urandom, 1'b0, 0);
        send_packet(dpd_pkg::MODE_WAVE, $urandom, 1'b1, 0);

        settle();
        if (fails == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
